@@ hw/rtl/omav_pkg.sv @@
// shared constants, types and controller codes for the oversample moving average unit
// no dependencies; used by every other file of the block except omav_divider
package omav_pkg;

  localparam int DEFAULT_WINDOW_LEN  = 10;
  localparam int DEFAULT_SAMPLE_BITS = 12;

  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd100;
  localparam int MEAN_W = 16;
  localparam int FRAC_BITS = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_PRIME,
    ST_READ,
    ST_UPDATE,
    ST_FILT,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start_mean;
    logic load_mean;
    logic prime;
    logic read_slot;
    logic update;
    logic load_filt;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic group_end;
    logic div_done;
    logic primed;
    logic out_busy;
  } status_t;

endpackage

@@ hw/rtl/omav_if.sv @@
// stream interfaces for sample items and result items
// depends on omav_pkg for default widths
interface omav_in_if #(
  parameter int SAMPLE_BITS = omav_pkg::DEFAULT_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface omav_out_if;
  logic                        valid;
  logic                        ready;
  logic [omav_pkg::MEAN_W-1:0] oversampled_mean;
  logic [omav_pkg::MEAN_W-1:0] filtered_mean;

  modport source (output valid, output oversampled_mean, output filtered_mean, input ready);
  modport sink   (input valid, input oversampled_mean, input filtered_mean, output ready);
endinterface

@@ hw/rtl/omav_divider.sv @@
// restoring radix-2 divider, one quotient bit per cycle
// no package dependencies
module omav_divider #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divs;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[DIVIDEND_W-1]};
    diff     = {1'b0, shifted} - {2'b00, divs};
    fits     = ~diff[DIVISOR_W+1];
    rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      divs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

@@ hw/rtl/omav_datapath.sv @@
// group accumulator, mean divider, window ring buffer and output register
// depends on omav_pkg and omav_divider
module omav_datapath #(
  parameter int WINDOW_LEN  = omav_pkg::DEFAULT_WINDOW_LEN,
  parameter int SAMPLE_BITS = omav_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  omav_pkg::cmd_t               cmd,
  output omav_pkg::status_t            status,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic                         cfg_we,
  input  logic [omav_pkg::COUNT_W-1:0] cfg_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [omav_pkg::MEAN_W-1:0]  out_mean,
  output logic [omav_pkg::MEAN_W-1:0]  out_filt
);
  import omav_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + COUNT_W;
  localparam int TOT_W = MEAN_W + $clog2(WINDOW_LEN + 1);
  localparam int DIV_W = SUM_W + FRAC_BITS;
  localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // window mean by reciprocal multiply, exact for any total below 2**TOT_W
  localparam int RECIP_SH = TOT_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W  = TOT_W + 1;
  localparam int PROD_W   = TOT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   group_sum;
  logic [COUNT_W-1:0] group_fill;
  logic [SUM_W-1:0]   sum_inc;
  logic [COUNT_W-1:0] fill_inc;
  logic [COUNT_W-1:0] count_eff;

  logic [MEAN_W-1:0]  mean;
  logic [MEAN_W-1:0]  prime_mean;
  logic [MEAN_W-1:0]  filt;
  logic [TOT_W-1:0]   total;
  logic [PTR_W-1:0]   pointer;
  logic               wrapped;
  logic               primed;
  logic [PROD_W-1:0]  filt_prod;

  logic [MEAN_W-1:0]  slots [WINDOW_LEN];
  logic [MEAN_W-1:0]  slot_rd;
  logic [MEAN_W-1:0]  old_mean;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [COUNT_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quotient;
  logic [MEAN_W-1:0]  quot_sat;

  always_comb begin
    sum_inc   = group_sum + SUM_W'(sample);
    fill_inc  = group_fill + 1'b1;
    count_eff = (count == '0) ? COUNT_W'(1) : count;
    status.group_end = (fill_inc == '0) || (fill_inc >= count_eff);
    status.div_done  = div_done;
    status.primed    = primed;
    status.out_busy  = out_valid && !out_ready;
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RESET;
    end else if (cfg_we) begin
      count <= cfg_data;
    end
  end

  // group accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum  <= '0;
      group_fill <= '0;
    end else if (cmd.accept) begin
      if (status.group_end) begin
        group_sum  <= '0;
        group_fill <= '0;
      end else begin
        group_sum  <= sum_inc;
        group_fill <= fill_inc;
      end
    end
  end

  // group mean: sum * 16 / count, one quotient bit per cycle
  always_comb begin
    div_start    = cmd.start_mean;
    div_dividend = {sum_inc, {FRAC_BITS{1'b0}}};
    div_divisor  = count_eff;
    quot_sat     = (|div_quotient[DIV_W-1:MEAN_W]) ? {MEAN_W{1'b1}}
                                                   : div_quotient[MEAN_W-1:0];
    filt_prod    = PROD_W'(total) * PROD_W'(RECIP);
  end

  omav_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (COUNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // slots not yet rewritten since priming count as holding the priming mean
  assign old_mean = wrapped ? slot_rd : prime_mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed  <= 1'b0;
      wrapped <= 1'b0;
      pointer <= '0;
    end else begin
      if (cmd.prime) begin
        primed <= 1'b1;
      end
      if (cmd.update) begin
        if (pointer == PTR_W'(WINDOW_LEN - 1)) begin
          pointer <= '0;
          wrapped <= 1'b1;
        end else begin
          pointer <= pointer + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mean) begin
      mean <= quot_sat;
    end
    if (cmd.prime) begin
      prime_mean <= mean;
      total      <= TOT_W'(mean) * TOT_W'(WINDOW_LEN);
      filt       <= mean;
    end
    if (cmd.update) begin
      total <= total + TOT_W'(mean) - TOT_W'(old_mean);
    end
    if (cmd.load_filt) begin
      filt <= filt_prod[RECIP_SH +: MEAN_W];
    end
  end

  // ring buffer memory
  always_ff @(posedge clk) begin
    if (cmd.read_slot) begin
      slot_rd <= slots[pointer];
    end
    if (cmd.update) begin
      slots[pointer] <= mean;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mean <= mean;
      out_filt <= filt;
    end
  end

endmodule

@@ hw/rtl/omav_controller.sv @@
// sequencer for accumulate, divide, window update and result hand-off
// depends on omav_pkg
module omav_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  omav_pkg::status_t status,
  output omav_pkg::cmd_t    cmd
);
  import omav_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.group_end) begin
            cmd.start_mean = 1'b1;
            state_next     = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (status.div_done) begin
          cmd.load_mean = 1'b1;
          state_next    = status.primed ? ST_READ : ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_READ: begin
        cmd.read_slot = 1'b1;
        state_next    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FILT;
      end
      ST_FILT: begin
        cmd.load_filt = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/oversample_moving_average_unit.sv @@
// top level: oversampling decimator feeding a boxcar moving average
// depends on omav_pkg, omav_if, omav_controller, omav_datapath, omav_divider
// a sample inside a group is only accumulated; a group-ending sample yields its item
//   after the divide and window steps (24-bit divider at defaults), fewer when it primes the window
// input is taken again once that item enters the output register, later while an item waits
// synchronous active-high reset: count back to 100, group and window cleared, no item held
module oversample_moving_average_unit #(
  parameter int WINDOW_LEN  = omav_pkg::DEFAULT_WINDOW_LEN,
  parameter int SAMPLE_BITS = omav_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  omav_in_if.sink                      in_ch,
  omav_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [omav_pkg::COUNT_W-1:0] cfg_data
);
  import omav_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: takes an item only while idle, and after a group-ending one walks the divide and window steps
  omav_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: accumulator, divider, ring buffer, output register
  // the output register lets the next sample in while a result waits
  omav_datapath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (in_ch.sample),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_mean  (out_ch.oversampled_mean),
    .out_filt  (out_ch.filtered_mean)
  );

endmodule

@@ hw/rtl/omav_checker.sv @@
// port-level assertions for the oversample moving average unit, with its bind
// depends on omav_pkg
module omav_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [omav_pkg::MEAN_W-1:0] oversampled_mean,
  input logic [omav_pkg::MEAN_W-1:0] filtered_mean
);
  logic seen_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_result <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_result <= 1'b1;
    end
  end

  // reset leaves no item pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(oversampled_mean)
                                && $stable(filtered_mean))
    else $error("stalled item changed");

  // the first item after reset primes the window, so the two means agree
  a_prime_pass: assert property (@(posedge clk) disable iff (rst)
    out_valid && !seen_result |-> filtered_mean == oversampled_mean)
    else $error("first filtered mean differs from group mean");

endmodule

bind oversample_moving_average_unit omav_checker u_omav_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .oversampled_mean (out_ch.oversampled_mean),
  .filtered_mean    (out_ch.filtered_mean)
);
